@@ hw/rtl/csa_pkg.sv @@
// types, constants and grading functions for the crash severity analyzer
package csa_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FILT_W      = 32;
	localparam int VEL_W       = 40;
	localparam int PEAK_W      = 16;
	localparam int DV_W        = 24;
	localparam int ACC_W       = 38;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DECIM     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_LIM  = 3'd7;

	localparam logic [19:0] ROLL_LIM_RESET = 20'd2000;

	// rollover and impact watch limits (Q7.8 g)
	localparam logic signed [15:0] Z_TILT_MAX  = 16'sd128;
	localparam logic [16:0]        Y_TILT_MIN  = 17'd222;
	localparam logic [32:0]        IMPACT_SQ   = 33'd147456;

	// start and end point search limits (Q15.16 g)
	localparam logic [31:0] START_LIM_WIDE = 32'd98304;
	localparam logic [31:0] START_LIM_TIGHT = 32'd65536;
	localparam logic [36:0] END_RATIO      = 37'd20;

	// per-axis grading limits
	localparam logic [16:0] AP_HI   = 17'd3328;
	localparam logic [16:0] AP_MID  = 17'd1280;
	localparam logic [16:0] AP_LO   = 17'd768;
	localparam logic [24:0] ADV_HI  = 25'd5760;
	localparam logic [24:0] ADV_LO  = 25'd3277;

	// overall grading limits on squared magnitudes
	localparam logic [32:0] P2_HI   = 33'd11075584;
	localparam logic [32:0] P2_LO   = 33'd1638400;
	localparam logic [48:0] D2_HI   = 49'd33177600;
	localparam logic [48:0] D2_LO   = 49'd10737419;

	localparam logic [1:0] SEV_NONE     = 2'd0;
	localparam logic [1:0] SEV_MODERATE = 2'd1;
	localparam logic [1:0] SEV_HIGH     = 2'd2;
	localparam logic [1:0] SEV_EXTREME  = 2'd3;

	localparam logic [1:0] OVR_MODERATE = 2'd0;
	localparam logic [1:0] OVR_HIGH     = 2'd1;
	localparam logic [1:0] OVR_EXTREME  = 2'd2;

	localparam logic EVT_COLLISION = 1'b0;
	localparam logic EVT_ROLLOVER  = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic                          last_sample;
	} sample_t;

	typedef struct packed {
		logic                     event_type;
		logic signed [PEAK_W-1:0] peak_x;
		logic signed [PEAK_W-1:0] peak_y;
		logic signed [DV_W-1:0]   delta_v_x;
		logic signed [DV_W-1:0]   delta_v_y;
		logic [1:0]               severity_x;
		logic [1:0]               severity_y;
		logic [1:0]               severity_overall;
		logic                     front_impact;
		logic                     right_impact;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_BWD,
		ST_DEC,
		ST_BSRCH,
		ST_FSRCH,
		ST_VEL,
		ST_GRADE
	} state_t;

	// grade one axis from its peak and delta-v
	function automatic logic [1:0] grade_axis(input logic signed [PEAK_W-1:0] p,
		input logic signed [DV_W-1:0] dv);
		logic signed [PEAK_W:0] pe;
		logic signed [DV_W:0]   de;
		logic [PEAK_W:0]        ap;
		logic [DV_W:0]          adv;
		logic                   l3;
		logic                   l2;
		logic [1:0]             g;
		pe  = (PEAK_W+1)'(p);
		de  = (DV_W+1)'(dv);
		ap  = pe[PEAK_W] ? (PEAK_W+1)'(-pe) : (PEAK_W+1)'(pe);
		adv = de[DV_W] ? (DV_W+1)'(-de) : (DV_W+1)'(de);
		l3  = (ap > AP_HI) || (adv > ADV_HI);
		l2  = (ap >= AP_MID && ap <= AP_HI) || (adv >= ADV_LO && adv <= ADV_HI);
		if (l3) g = SEV_EXTREME;
		else if (l2) g = SEV_HIGH;
		else if (ap < AP_LO) g = SEV_NONE;
		else g = SEV_MODERATE;
		return g;
	endfunction

	// grade the combined result from squared magnitudes
	function automatic logic [1:0] grade_overall(input logic [32:0] p2,
		input logic [48:0] d2);
		logic       l3;
		logic       l2;
		logic [1:0] g;
		l3 = (p2 > P2_HI) || (d2 > D2_HI);
		l2 = (p2 >= P2_LO && p2 <= P2_HI) || (d2 >= D2_LO && d2 <= D2_HI);
		if (l3) g = OVR_EXTREME;
		else if (l2) g = OVR_HIGH;
		else g = OVR_MODERATE;
		return g;
	endfunction

endpackage

@@ hw/rtl/crash_severity_analyzer_core.sv @@
// crash severity analyzer: sample capture, rollover watch and record analysis
//
// Samples are taken one per clock while busy is low (start high). A record ends
// with the sample marked last_sample. If rollover was seen, the result follows in
// the next cycle and the block stays ready. Otherwise busy rises and the record is
// analyzed from the sample memories with one shared 32x32 multiplier: per axis
// a forward filter pass and a backward pass (five coefficient products and a
// memory read/write per sample), decimation and integration over m elements
// (m = ceil(n/decim)), the start and end point searches and the delta-v reads;
// grading follows once both axes are done. done pulses for exactly one cycle
// with the result, which must be taken then since the receiver cannot stall.
module crash_severity_analyzer_core #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  csa_pkg::sample_t                    sample,
	input  logic                                cfg_we,
	input  logic [csa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [csa_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                done,
	output csa_pkg::result_t                    result
);

	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SB     = csa_pkg::SAMPLE_BITS;
	localparam int FW     = csa_pkg::FILT_W;
	localparam int VW     = csa_pkg::VEL_W;

	// sequencer steps
	localparam logic [3:0] S_ISSUE = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_MB0   = 4'd2;
	localparam logic [3:0] S_MB1   = 4'd3;
	localparam logic [3:0] S_MB2   = 4'd4;
	localparam logic [3:0] S_MA1   = 4'd5;
	localparam logic [3:0] S_MA2   = 4'd6;
	localparam logic [3:0] S_SUB2  = 4'd7;
	localparam logic [3:0] S_WRITE = 4'd8;
	localparam logic [3:0] S_GLAST = 4'd5;

	// configuration registers
	logic signed [31:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [6:0]         decim_q;
	logic [23:0]        vel_gain_q;
	logic [19:0]        roll_limit_q;

	// control state
	csa_pkg::state_t    state_q, state_nx;
	logic [3:0]         step_q, step_nx;
	logic               axis_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [19:0]        tilt_q;
	logic               roll_q;
	logic               imp_q;
	logic               done_q;

	// datapath registers
	logic [CNT_W-1:0]        n_q;
	logic [ADDR_W-1:0]       idx_q;
	logic [CNT_W:0]          addr_q;
	logic [ADDR_W-1:0]       m_last_q, j_q, end1_q, end2_q;
	logic                    ph_q;
	logic signed [FW-1:0]    cur_q, x1_q, x2_q, y1_q, y2_q;
	logic signed [csa_pkg::ACC_W-1:0] acc_q;
	logic signed [VW-1:0]    vacc_q, v2_q;
	logic signed [FW-1:0]    pk_q;
	logic [FW-1:0]           apk_q;
	logic signed [15:0]      peak_x_q, peak_y_q;
	logic signed [23:0]      dvx_q, dvy_q;
	logic [32:0]             p2_q;
	logic [48:0]             d2_q;
	logic signed [63:0]      prod_s1;
	csa_pkg::result_t        res_q;

	// memories
	logic signed [SB-1:0] raw_x_mem [MAX_SAMPLES];
	logic signed [SB-1:0] raw_y_mem [MAX_SAMPLES];
	logic signed [FW-1:0] fw_mem    [MAX_SAMPLES];
	logic signed [FW-1:0] dec_mem   [MAX_SAMPLES];
	logic signed [VW-1:0] vel_mem   [MAX_SAMPLES];

	logic signed [SB-1:0] raw_x_rd, raw_y_rd;
	logic signed [FW-1:0] fw_rd, dec_rd;
	logic signed [VW-1:0] vel_rd;

	logic                 raw_we, fw_we, dec_we, vel_we;
	logic [ADDR_W-1:0]    fw_ra, vel_ra;
	logic signed [FW-1:0] fw_wd;

	logic signed [31:0]   mul_a, mul_b;

	// saturate filter accumulator to 32 bits
	function automatic logic signed [FW-1:0] sat_flt(input logic signed [csa_pkg::ACC_W-1:0] v);
		logic signed [FW-1:0] r;
		if (v[csa_pkg::ACC_W-1:FW-1] == {(csa_pkg::ACC_W-FW+1){v[csa_pkg::ACC_W-1]}}) r = v[FW-1:0];
		else r = v[csa_pkg::ACC_W-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
		return r;
	endfunction

	// saturate a 41-bit velocity sum to 40 bits
	function automatic logic signed [VW-1:0] sat_vel(input logic signed [VW:0] v);
		logic signed [VW-1:0] r;
		if (v[VW] == v[VW-1]) r = v[VW-1:0];
		else r = v[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		return r;
	endfunction

	// saturate 33 bits to 24 bits
	function automatic logic signed [23:0] sat_dv(input logic signed [32:0] v);
		logic signed [23:0] r;
		if (v[32:23] == {10{v[32]}}) r = v[23:0];
		else r = v[32] ? 24'sh800000 : 24'sh7fffff;
		return r;
	endfunction

	// saturate 25 bits to 16 bits
	function automatic logic signed [15:0] sat_pk(input logic signed [24:0] v);
		logic signed [15:0] r;
		if (v[24:15] == {10{v[24]}}) r = v[15:0];
		else r = v[24] ? 16'sh8000 : 16'sh7fff;
		return r;
	endfunction

	// sample beat and rollover watch
	logic                   accept, full, watch, tilt_hit, impact_hit, roll_set, roll_now;
	logic                   go, roll_done;
	logic signed [16:0]     ay_ext;
	logic [16:0]            ay_mag;
	logic signed [31:0]     sq_x, sq_y;
	logic [32:0]            sum_sq;
	logic [19:0]            tilt_inc;
	logic [CNT_W-1:0]       n_rec;

	always_comb begin
		accept     = start & ~busy;
		full       = (cnt_q == CNT_W'(MAX_SAMPLES));
		watch      = ~full & ~roll_q & ~imp_q;
		ay_ext     = 17'(sample.accel_y);
		ay_mag     = ay_ext[16] ? 17'(-ay_ext) : 17'(ay_ext);
		tilt_hit   = (sample.accel_z < csa_pkg::Z_TILT_MAX) && (ay_mag >= csa_pkg::Y_TILT_MIN);
		sq_x       = sample.accel_x * sample.accel_x;
		sq_y       = sample.accel_y * sample.accel_y;
		sum_sq     = {1'b0, sq_x} + {1'b0, sq_y};
		impact_hit = (sum_sq >= csa_pkg::IMPACT_SQ);
		tilt_inc   = tilt_q + 20'd1;
		roll_set   = watch & tilt_hit & (tilt_inc == roll_limit_q);
		roll_now   = roll_q | roll_set;
		go         = accept & sample.last_sample & ~roll_now;
		roll_done  = accept & sample.last_sample & roll_now;
		n_rec      = full ? cnt_q : cnt_q + CNT_W'(1);
	end

	// arithmetic around the shared multiplier and memories
	logic [6:0]             dstep;
	logic signed [63:0]     flt_sum, vel_sum;
	logic signed [33:0]     flt_term;
	logic signed [VW-1:0]   vel_term, vel_new;
	logic signed [FW-1:0]   raw_x0, flt_y;
	logic signed [SB-1:0]   raw_sel;
	logic [FW-1:0]          fmag, dmag;
	logic [36:0]            dmag20;
	logic                   hit_wide, hit_tight, hit_end;
	logic                   fwd_last, bwd_last, dec_last, bs_stop, fs_stop;
	logic signed [VW:0]     dv_diff;
	logic signed [VW:0]     dv_rsum;
	logic signed [32:0]     pk_rsum;
	logic signed [15:0]     peak_new;
	logic signed [23:0]     dv_new;

	always_comb begin
		dstep     = (decim_q == 7'd0) ? 7'd1 : decim_q;
		flt_sum   = prod_s1 + 64'sd536870912;
		flt_term  = flt_sum[63:30];
		vel_sum   = prod_s1 + 64'sd8388608;
		vel_term  = vel_sum[63:24];
		vel_new   = sat_vel((VW+1)'(vacc_q) + (VW+1)'(vel_term));
		raw_sel   = axis_q ? raw_y_rd : raw_x_rd;
		raw_x0    = {{(FW-SB-8){raw_sel[SB-1]}}, raw_sel, 8'b0};
		flt_y     = sat_flt(acc_q);
		fmag      = fw_rd[FW-1] ? (~fw_rd + 32'd1) : fw_rd;
		dmag      = dec_rd[FW-1] ? (~dec_rd + 32'd1) : dec_rd;
		dmag20    = 37'(dmag) * csa_pkg::END_RATIO;
		hit_wide  = (dmag <= csa_pkg::START_LIM_WIDE);
		hit_tight = (dmag <= csa_pkg::START_LIM_TIGHT);
		hit_end   = (dmag20 <= 37'(apk_q));
		fwd_last  = (CNT_W'(idx_q) == n_q - CNT_W'(1));
		bwd_last  = (idx_q == '0);
		dec_last  = ((addr_q + (CNT_W+1)'(dstep)) >= {1'b0, n_q});
		bs_stop   = (idx_q == '0) || (ph_q && hit_tight);
		fs_stop   = hit_end || (idx_q == m_last_q);
		dv_diff   = (VW+1)'(v2_q) - (VW+1)'(vel_rd);
		dv_rsum   = dv_diff + (VW+1)'(128);
		dv_new    = sat_dv(dv_rsum[VW:8]);
		pk_rsum   = 33'(pk_q) + 33'sd128;
		peak_new  = sat_pk(pk_rsum[32:8]);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		step_nx  = step_q;
		unique case (state_q)
			csa_pkg::ST_IDLE: begin
				step_nx = S_ISSUE;
				if (go) state_nx = csa_pkg::ST_FWD;
			end
			csa_pkg::ST_FWD: begin
				if (step_q == S_WRITE) begin
					step_nx = S_ISSUE;
					if (fwd_last) state_nx = csa_pkg::ST_BWD;
				end else begin
					step_nx = step_q + 4'd1;
				end
			end
			csa_pkg::ST_BWD: begin
				if (step_q == S_WRITE) begin
					step_nx = S_ISSUE;
					if (bwd_last) state_nx = csa_pkg::ST_DEC;
				end else begin
					step_nx = step_q + 4'd1;
				end
			end
			csa_pkg::ST_DEC: begin
				if (step_q == S_MB0) begin
					step_nx = S_ISSUE;
					if (dec_last) state_nx = csa_pkg::ST_BSRCH;
				end else begin
					step_nx = step_q + 4'd1;
				end
			end
			csa_pkg::ST_BSRCH: begin
				if (step_q == S_LOAD) begin
					step_nx = S_ISSUE;
					if (bs_stop) state_nx = csa_pkg::ST_FSRCH;
				end else begin
					step_nx = S_LOAD;
				end
			end
			csa_pkg::ST_FSRCH: begin
				if (step_q == S_LOAD) begin
					step_nx = S_ISSUE;
					if (fs_stop) state_nx = csa_pkg::ST_VEL;
				end else begin
					step_nx = S_LOAD;
				end
			end
			csa_pkg::ST_VEL: begin
				if (step_q == S_MB0) begin
					step_nx  = S_ISSUE;
					state_nx = axis_q ? csa_pkg::ST_GRADE : csa_pkg::ST_FWD;
				end else begin
					step_nx = step_q + 4'd1;
				end
			end
			csa_pkg::ST_GRADE: begin
				if (step_q == S_GLAST) begin
					step_nx  = S_ISSUE;
					state_nx = csa_pkg::ST_IDLE;
				end else begin
					step_nx = step_q + 4'd1;
				end
			end
			default: begin
				state_nx = csa_pkg::ST_IDLE;
				step_nx  = S_ISSUE;
			end
		endcase
	end

	// outputs: handshake, memory controls and multiplier operands
	always_comb begin
		busy   = (state_q != csa_pkg::ST_IDLE);
		raw_we = accept & ~full;
		fw_we  = (state_q == csa_pkg::ST_FWD || state_q == csa_pkg::ST_BWD) &&
			(step_q == S_WRITE);
		fw_wd  = flt_y;
		dec_we = (state_q == csa_pkg::ST_DEC) && (step_q == S_LOAD);
		vel_we = (state_q == csa_pkg::ST_DEC) && (step_q == S_MB0);
		fw_ra  = (state_q == csa_pkg::ST_DEC) ? addr_q[ADDR_W-1:0] : idx_q;
		vel_ra = (step_q == S_ISSUE) ? end2_q : end1_q;
		mul_a  = b0_q;
		mul_b  = cur_q;
		unique case (state_q)
			csa_pkg::ST_FWD, csa_pkg::ST_BWD: begin
				priority case (step_q)
					S_MB1: begin mul_a = b1_q; mul_b = x1_q; end
					S_MB2: begin mul_a = b2_q; mul_b = x2_q; end
					S_MA1: begin mul_a = a1_q; mul_b = y1_q; end
					S_MA2: begin mul_a = a2_q; mul_b = y2_q; end
					default: begin mul_a = b0_q; mul_b = cur_q; end
				endcase
			end
			csa_pkg::ST_DEC: begin
				mul_a = fw_rd;
				mul_b = $signed({8'b0, vel_gain_q});
			end
			csa_pkg::ST_GRADE: begin
				priority case (step_q)
					S_ISSUE: begin mul_a = 32'(peak_x_q); mul_b = 32'(peak_x_q); end
					S_LOAD:  begin mul_a = 32'(peak_y_q); mul_b = 32'(peak_y_q); end
					S_MB0:   begin mul_a = 32'(dvx_q); mul_b = 32'(dvx_q); end
					default: begin mul_a = 32'(dvy_q); mul_b = 32'(dvy_q); end
				endcase
			end
			default: begin
				mul_a = b0_q;
				mul_b = cur_q;
			end
		endcase
		done   = done_q;
		result = res_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q         <= '0;
			b1_q         <= '0;
			b2_q         <= '0;
			a1_q         <= '0;
			a2_q         <= '0;
			decim_q      <= 7'd1;
			vel_gain_q   <= '0;
			roll_limit_q <= csa_pkg::ROLL_LIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csa_pkg::CFG_COEF_B0:  b0_q <= $signed(cfg_data);
				csa_pkg::CFG_COEF_B1:  b1_q <= $signed(cfg_data);
				csa_pkg::CFG_COEF_B2:  b2_q <= $signed(cfg_data);
				csa_pkg::CFG_COEF_A1:  a1_q <= $signed(cfg_data);
				csa_pkg::CFG_COEF_A2:  a2_q <= $signed(cfg_data);
				csa_pkg::CFG_DECIM:    decim_q <= cfg_data[6:0];
				csa_pkg::CFG_VEL_GAIN: vel_gain_q <= cfg_data[23:0];
				csa_pkg::CFG_ROLL_LIM: roll_limit_q <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csa_pkg::ST_IDLE;
			step_q  <= S_ISSUE;
			axis_q  <= 1'b0;
			cnt_q   <= '0;
			tilt_q  <= '0;
			roll_q  <= 1'b0;
			imp_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			step_q  <= step_nx;
			done_q  <= roll_done ||
				(state_q == csa_pkg::ST_GRADE && step_q == S_GLAST);
			if (go) axis_q <= 1'b0;
			else if (state_q == csa_pkg::ST_VEL && step_q == S_MB0) axis_q <= 1'b1;
			if (accept) begin
				if (sample.last_sample) begin
					cnt_q  <= '0;
					tilt_q <= '0;
					roll_q <= 1'b0;
					imp_q  <= 1'b0;
				end else if (!full) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (watch) begin
						if (tilt_hit) begin
							tilt_q <= tilt_inc;
							if (roll_set) roll_q <= 1'b1;
						end else begin
							tilt_q <= '0;
							if (impact_hit) imp_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// sample memories
	always_ff @(posedge clk) begin
		if (raw_we) begin
			raw_x_mem[cnt_q[ADDR_W-1:0]] <= sample.accel_x;
			raw_y_mem[cnt_q[ADDR_W-1:0]] <= sample.accel_y;
		end
		raw_x_rd <= raw_x_mem[idx_q];
		raw_y_rd <= raw_y_mem[idx_q];
	end

	// filter work memory
	always_ff @(posedge clk) begin
		if (fw_we) fw_mem[idx_q] <= fw_wd;
		fw_rd <= fw_mem[fw_ra];
	end

	// decimated and velocity memories
	always_ff @(posedge clk) begin
		if (dec_we) dec_mem[idx_q] <= fw_rd;
		if (vel_we) vel_mem[idx_q] <= vel_new;
		dec_rd <= dec_mem[idx_q];
		vel_rd <= vel_mem[vel_ra];
	end

	// analysis datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			csa_pkg::ST_IDLE: begin
				if (go) begin
					n_q   <= n_rec;
					idx_q <= '0;
					x1_q  <= '0;
					x2_q  <= '0;
					y1_q  <= '0;
					y2_q  <= '0;
				end
				if (roll_done)
					res_q <= '{event_type: csa_pkg::EVT_ROLLOVER, default: '0};
			end
			csa_pkg::ST_FWD, csa_pkg::ST_BWD: begin
				priority case (step_q)
					S_LOAD: begin
						cur_q <= (state_q == csa_pkg::ST_FWD) ? raw_x0 : fw_rd;
						acc_q <= '0;
					end
					S_MB1, S_MB2, S_MA1: acc_q <= acc_q + csa_pkg::ACC_W'(flt_term);
					S_MA2, S_SUB2:       acc_q <= acc_q - csa_pkg::ACC_W'(flt_term);
					S_WRITE: begin
						if (state_q == csa_pkg::ST_FWD && fwd_last) begin
							// backward pass starts at the end with clear history
							idx_q <= ADDR_W'(n_q - CNT_W'(1));
							x1_q  <= '0;
							x2_q  <= '0;
							y1_q  <= '0;
							y2_q  <= '0;
						end else begin
							x2_q <= x1_q;
							x1_q <= cur_q;
							y2_q <= y1_q;
							y1_q <= flt_y;
							if (state_q == csa_pkg::ST_FWD) begin
								idx_q <= idx_q + ADDR_W'(1);
							end else if (bwd_last) begin
								idx_q  <= '0;
								addr_q <= '0;
								vacc_q <= '0;
							end else begin
								idx_q <= idx_q - ADDR_W'(1);
							end
						end
					end
					default: ;
				endcase
			end
			csa_pkg::ST_DEC: begin
				if (step_q == S_LOAD) begin
					// running peak, earliest index wins ties
					if (idx_q == '0 || fmag > apk_q) begin
						j_q   <= idx_q;
						pk_q  <= fw_rd;
						apk_q <= fmag;
					end
				end else if (step_q == S_MB0) begin
					vacc_q <= vel_new;
					if (dec_last) begin
						m_last_q <= idx_q;
						idx_q    <= j_q;
						ph_q     <= 1'b0;
						end1_q   <= '0;
					end else begin
						idx_q  <= idx_q + ADDR_W'(1);
						addr_q <= addr_q + (CNT_W+1)'(dstep);
					end
				end
			end
			csa_pkg::ST_BSRCH: begin
				if (step_q == S_LOAD) begin
					// first the wide limit, then the tight limit further back
					if (!ph_q && hit_wide) begin
						end1_q <= idx_q;
						ph_q   <= 1'b1;
					end
					if (ph_q && hit_tight) end1_q <= idx_q;
					if (bs_stop) begin
						idx_q  <= j_q;
						end2_q <= m_last_q;
					end else begin
						idx_q <= idx_q - ADDR_W'(1);
					end
				end
			end
			csa_pkg::ST_FSRCH: begin
				if (step_q == S_LOAD) begin
					if (hit_end) end2_q <= idx_q;
					if (!fs_stop) idx_q <= idx_q + ADDR_W'(1);
				end
			end
			csa_pkg::ST_VEL: begin
				if (step_q == S_LOAD) begin
					v2_q <= vel_rd;
				end else if (step_q == S_MB0) begin
					if (axis_q) begin
						peak_y_q <= peak_new;
						dvy_q    <= dv_new;
					end else begin
						peak_x_q <= peak_new;
						dvx_q    <= dv_new;
						idx_q    <= '0;
						x1_q     <= '0;
						x2_q     <= '0;
						y1_q     <= '0;
						y2_q     <= '0;
					end
				end
			end
			csa_pkg::ST_GRADE: begin
				priority case (step_q)
					S_LOAD: p2_q <= prod_s1[32:0];
					S_MB0:  p2_q <= p2_q + prod_s1[32:0];
					S_MB1:  d2_q <= prod_s1[48:0];
					S_MB2:  d2_q <= d2_q + prod_s1[48:0];
					S_GLAST: begin
						res_q.event_type       <= csa_pkg::EVT_COLLISION;
						res_q.peak_x           <= peak_x_q;
						res_q.peak_y           <= peak_y_q;
						res_q.delta_v_x        <= dvx_q;
						res_q.delta_v_y        <= dvy_q;
						res_q.severity_x       <= csa_pkg::grade_axis(peak_x_q, dvx_q);
						res_q.severity_y       <= csa_pkg::grade_axis(peak_y_q, dvy_q);
						res_q.severity_overall <= csa_pkg::grade_overall(p2_q, d2_q);
						res_q.front_impact     <= peak_x_q[15];
						res_q.right_impact     <= peak_y_q[15];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule
